// ----- design/ascii_to_integer_parser_core_assert.svh -----
// ============================================================================
// ASCII to integer parser assertion macros
// Shorthand for the concurrent checks of the parser, clocked on the rising
// edge and held off while the asynchronous reset is asserted.
// ============================================================================
`ifndef ASCII_TO_INTEGER_PARSER_CORE_ASSERT_SVH
`define ASCII_TO_INTEGER_PARSER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define A2I_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define A2I_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/a2i_pkg.sv -----
// ============================================================================
// ASCII to integer parser package
// Shared widths, output word layout and the classified character word that
// travels from the front end through the queue to the back end.
// ============================================================================
`default_nettype none

package a2i_pkg;

	// Longest position tracked; the character index saturates here.
	localparam int MAX_LEN = 4096;
	localparam int IDX_W   = $clog2(MAX_LEN + 1);

	localparam int CHAR_W  = 8;
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 5;
	localparam int VALUE_W = 64;

	// Radix after reset.
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	// Digit code of a character that is no digit in any base.
	localparam logic [DIGIT_W-1:0] NOT_DIGIT = DIGIT_W'(16);

	// Result word layout, lowest bit first: value, stop index, overflow, digits seen.
	localparam int OUT_STOP_LSB = VALUE_W;
	localparam int OUT_OVF_BIT  = OUT_STOP_LSB + IDX_W;
	localparam int OUT_SEEN_BIT = OUT_OVF_BIT + 1;
	localparam int OUT_USED_W   = OUT_SEEN_BIT + 1;
	localparam int OUT_W        = ((OUT_USED_W + 7) / 8) * 8;

	// Queue between the front and back ends.
	localparam int QUEUE_AW    = 1;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	// One character after classification.
	typedef struct packed {
		logic [DIGIT_W-1:0] digit;    // digit value, NOT_DIGIT when none
		logic               is_space;
		logic               is_minus;
		logic               pfx_hex;  // x or X
		logic               pfx_bin;  // b or B
		logic               pfx_dec;  // d or D
		logic               last;
	} class_t;

endpackage

`default_nettype wire

// ----- design/ascii_to_integer_parser_core.sv -----
// ============================================================================
// ASCII to integer parser
// Converts a character stream into signed 64-bit integers in the manner of
// strtoll, with white space skip, minus sign and base prefix detection.
// ============================================================================
// Usage:
// Characters arrive one word at a time on the s_axis channel, tdata holding
// the character and tlast marking the final character of a string. Each
// string yields one result word on the m_axis channel when its final
// character has been processed: value, stop index, overflow and digits seen.
// The radix register (2 to 16, or 0 for prefix detection) is written through
// radix_wr_en and radix_wr_data by the user, between strings only (unchecked).
// Throughput is one character per cycle while the queue has room, set by the
// single multiply-add by the base in the back end. A final character is
// queued, then popped into the result register as a result word.
// Reset clears the queue, the parse state and the result register and sets
// the radix to 10. When the receiver stalls, the result word is held, the
// back end keeps consuming characters up to the next final character, then
// the two-entry queue fills and s_axis_tready drops.
// ============================================================================
`default_nettype none

module ascii_to_integer_parser_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          radix_wr_en,
	input  wire logic [a2i_pkg::RADIX_W-1:0]   radix_wr_data,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [a2i_pkg::CHAR_W-1:0]    s_axis_tdata,  // [7:0] char_code
	input  wire logic                          s_axis_tlast,  // last_char
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [63:0] value, [76:64] stop_index, [77] overflowed, [78] digits_seen
	output logic [a2i_pkg::OUT_W-1:0]          m_axis_tdata
);
	import a2i_pkg::*;

	logic   queue_ready;
	logic   push;
	class_t push_data;
	logic   q_valid;
	logic   q_pop;
	class_t q_data;

	// Character classification and input handshake.
	a2i_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.queue_ready   (queue_ready),
		.push          (push),
		.push_data     (push_data)
	);

	// Queue between the two halves.
	a2i_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.ready     (queue_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_data)
	);

	// Parse state machine and result register.
	a2i_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.radix_wr_en   (radix_wr_en),
		.radix_wr_data (radix_wr_data),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire

// ----- design/a2i_front.sv -----
// ============================================================================
// ASCII to integer parser front end
// Accepts input words and classifies each character: digit value, white
// space, minus sign and prefix letters. The result is pushed into the queue.
// ============================================================================
`default_nettype none

module a2i_front (
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [a2i_pkg::CHAR_W-1:0]  s_axis_tdata,  // [7:0] char_code
	input  wire logic                        s_axis_tlast,  // last_char
	input  wire logic                        queue_ready,
	output logic                             push,
	output a2i_pkg::class_t                  push_data
);
	import a2i_pkg::*;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UP_B  = 8'h42;
	localparam logic [CHAR_W-1:0] CH_LO_B  = 8'h62;
	localparam logic [CHAR_W-1:0] CH_UP_D  = 8'h44;
	localparam logic [CHAR_W-1:0] CH_LO_D  = 8'h64;
	// Offsets that map letters onto digit values 10 to 15.
	localparam logic [CHAR_W-1:0] UP_OFFSET = 8'h37;
	localparam logic [CHAR_W-1:0] LO_OFFSET = 8'h57;

	// Digit value of a character in the widest base.
	function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		d = NOT_DIGIT;
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			d = DIGIT_W'(c - CH_ZERO);
		end else if (c inside {[CH_UP_A:CH_UP_F]}) begin
			d = DIGIT_W'(c - UP_OFFSET);
		end else if (c inside {[CH_LO_A:CH_LO_F]}) begin
			d = DIGIT_W'(c - LO_OFFSET);
		end
		return d;
	endfunction

	// Handshake: a word is taken whenever the queue has room.
	assign s_axis_tready = queue_ready;
	assign push          = s_axis_tvalid && queue_ready;

	// Character classification.
	always_comb begin
		push_data.digit    = digit_of(s_axis_tdata);
		push_data.is_space = (s_axis_tdata == CH_SPACE) ||
		                     (s_axis_tdata inside {[CH_TAB:CH_CR]});
		push_data.is_minus = (s_axis_tdata == CH_MINUS);
		push_data.pfx_hex  = (s_axis_tdata == CH_LO_X) || (s_axis_tdata == CH_UP_X);
		push_data.pfx_bin  = (s_axis_tdata == CH_LO_B) || (s_axis_tdata == CH_UP_B);
		push_data.pfx_dec  = (s_axis_tdata == CH_LO_D) || (s_axis_tdata == CH_UP_D);
		push_data.last     = s_axis_tlast;
	end

endmodule

`default_nettype wire

// ----- design/a2i_queue.sv -----
// ============================================================================
// ASCII to integer parser queue
// Short first-in first-out buffer of classified characters that lets the
// front and back ends stall independently.
// ============================================================================
`default_nettype none

module a2i_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire a2i_pkg::class_t push_data,
	output logic                 ready,
	input  wire logic            pop,
	output logic                 valid,
	output a2i_pkg::class_t      pop_data
);
	import a2i_pkg::*;

	class_t               entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_AW:0]    count_q;

	assign ready    = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Storage, written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/a2i_back.sv -----
// ============================================================================
// ASCII to integer parser back end
// Runs the parse state machine on one classified character per cycle unless
// stalled, accumulates the magnitude and holds the result for the receiver.
// ============================================================================
`default_nettype none

module a2i_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          radix_wr_en,
	input  wire logic [a2i_pkg::RADIX_W-1:0]   radix_wr_data,
	input  wire logic                          q_valid,
	input  wire a2i_pkg::class_t               q_data,
	output logic                               q_pop,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [a2i_pkg::OUT_W-1:0]          m_axis_tdata
);
	import a2i_pkg::*;

	localparam int PROD_W = VALUE_W + RADIX_W;

	typedef enum logic [2:0] {
		PH_WS,
		PH_SIGN,
		PH_ZERO,
		PH_PREFIX,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	localparam logic [RADIX_W-1:0] BASE_BIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] BASE_OCT = RADIX_W'(8);
	localparam logic [RADIX_W-1:0] BASE_DEC = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] BASE_HEX = RADIX_W'(16);
	localparam logic [RADIX_W-1:0] RADIX_AUTO = '0;
	localparam logic [DIGIT_W-1:0] DIGIT_ZERO = '0;
	localparam logic [DIGIT_W-1:0] DIGIT_OCT  = DIGIT_W'(8);
	localparam logic [DIGIT_W-1:0] DIGIT_DEC  = DIGIT_W'(10);
	localparam logic [IDX_W-1:0]   IDX_MAX    = IDX_W'(MAX_LEN);

	logic [RADIX_W-1:0] radix_q;

	phase_t             phase_q, phase_d;
	logic [VALUE_W-1:0] mag_q, mag_d;
	logic [RADIX_W-1:0] base_q, base_d;
	logic               neg_q, neg_d;
	logic [IDX_W-1:0]   idx_q, idx_next;
	logic [IDX_W-1:0]   stop_q, stop_d;
	logic               ovf_q, ovf_d;

	logic               start;
	logic               take;
	logic [RADIX_W-1:0] base_sel;
	logic [PROD_W-1:0]  prod;
	logic [VALUE_W-1:0] limit;
	logic [VALUE_W-1:0] value_out;

	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	// Radix register, written by the user between strings only (unchecked).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_wr_en) begin
			radix_q <= radix_wr_data;
		end
	end

	// A final character waits while the result register is still occupied.
	assign q_pop = q_valid && (!q_data.last || !out_valid_q || m_axis_tready);

	// Saturating character position.
	assign idx_next = (idx_q == IDX_MAX) ? IDX_MAX : idx_q + 1'b1;

	// Saturation bound: 2^63 for a negative number, 2^63-1 otherwise.
	assign limit = {neg_d, {(VALUE_W-1){~neg_d}}};

	// One multiply-add by the base per digit.
	assign prod = PROD_W'(mag_q) * PROD_W'(base_sel) + PROD_W'(q_data.digit);

	// Next parse state for the character at the head of the queue.
	always_comb begin
		phase_d  = phase_q;
		mag_d    = mag_q;
		base_d   = base_q;
		neg_d    = neg_q;
		stop_d   = stop_q;
		ovf_d    = ovf_q;
		start    = 1'b0;
		take     = 1'b0;
		base_sel = base_q;

		case (phase_q)
			PH_WS: begin
				if (q_data.is_space) begin
					phase_d = PH_WS;
				end else if (q_data.is_minus) begin
					neg_d   = 1'b1;
					phase_d = PH_SIGN;
				end else begin
					start = 1'b1;
				end
			end
			PH_SIGN: begin
				start = 1'b1;
			end
			PH_ZERO: begin
				if (q_data.pfx_hex) begin
					base_d  = BASE_HEX;
					phase_d = PH_PREFIX;
				end else if (q_data.pfx_bin) begin
					base_d  = BASE_BIN;
					phase_d = PH_PREFIX;
				end else if (q_data.pfx_dec) begin
					base_d  = BASE_DEC;
					phase_d = PH_PREFIX;
				end else if (q_data.digit < DIGIT_DEC) begin
					// A zero followed by a digit: octal unless the digit is 8 or 9.
					base_sel = (q_data.digit < DIGIT_OCT) ? BASE_OCT : BASE_DEC;
					base_d   = base_sel;
					take     = 1'b1;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_PREFIX, PH_DIGITS: begin
				take = 1'b1;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase

		// First character of the number proper; the radix is sampled here.
		if (start) begin
			if (radix_q == RADIX_AUTO) begin
				base_sel = BASE_DEC;
				base_d   = BASE_DEC;
				if (q_data.digit == DIGIT_ZERO) begin
					mag_d   = '0;
					stop_d  = idx_next;
					phase_d = PH_ZERO;
				end else begin
					take = 1'b1;
				end
			end else begin
				base_sel = (radix_q >= BASE_BIN && radix_q <= BASE_HEX) ? radix_q : '0;
				base_d   = base_sel;
				take     = 1'b1;
			end
		end

		// Digit accumulation with saturation.
		if (take) begin
			if (DIGIT_W'(base_sel) <= q_data.digit || base_sel < BASE_BIN) begin
				phase_d = PH_DONE;
			end else begin
				if (prod > PROD_W'(limit)) begin
					ovf_d = 1'b1;
					mag_d = limit;
				end else begin
					mag_d = prod[VALUE_W-1:0];
				end
				stop_d  = idx_next;
				phase_d = PH_DIGITS;
			end
		end
	end

	assign value_out = neg_d ? (~mag_d + 1'b1) : mag_d;

	// Parse state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WS;
			mag_q       <= '0;
			base_q      <= '0;
			neg_q       <= 1'b0;
			idx_q       <= '0;
			stop_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// A new result word replaces one that leaves in the same cycle.
			if (q_pop && q_data.last) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (q_data.last) begin
					phase_q     <= PH_WS;
					mag_q       <= '0;
					base_q      <= '0;
					neg_q       <= 1'b0;
					idx_q       <= '0;
					stop_q      <= '0;
					ovf_q       <= 1'b0;
					out_data_q  <= OUT_W'({(stop_d != '0), ovf_d, stop_d, value_out});
				end else begin
					phase_q <= phase_d;
					mag_q   <= mag_d;
					base_q  <= base_d;
					neg_q   <= neg_d;
					idx_q   <= idx_next;
					stop_q  <= stop_d;
					ovf_q   <= ovf_d;
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- design/a2i_checker.sv -----
// ============================================================================
// ASCII to integer parser port checker
// Watches the result channel of the top level and checks the consistency of
// each result word and its hold under back pressure.
// ============================================================================
`default_nettype none

`include "ascii_to_integer_parser_core_assert.svh"

module a2i_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        m_axis_tvalid,
	input wire logic                        m_axis_tready,
	input wire logic [a2i_pkg::OUT_W-1:0]   m_axis_tdata
);
	import a2i_pkg::*;

	localparam logic [VALUE_W-1:0] SAT_POS = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] SAT_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

	logic [VALUE_W-1:0] value;
	logic [IDX_W-1:0]   stop_index;
	logic               overflowed;
	logic               digits_seen;

	assign value       = m_axis_tdata[VALUE_W-1:0];
	assign stop_index  = m_axis_tdata[OUT_STOP_LSB +: IDX_W];
	assign overflowed  = m_axis_tdata[OUT_OVF_BIT];
	assign digits_seen = m_axis_tdata[OUT_SEEN_BIT];

	// A stalled result word stays put.
	`A2I_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

	// Digits seen exactly when the stop index moved.
	`A2I_ASSERT_SAME(a_seen_stop, clk, arst_n, m_axis_tvalid, digits_seen == (stop_index != '0), "digits seen disagrees with stop index")

	// The stop index never passes the saturation point.
	`A2I_ASSERT_SAME(a_stop_range, clk, arst_n, m_axis_tvalid, stop_index <= IDX_W'(MAX_LEN), "stop index beyond maximum length")

	// An overflowed result carries a saturated value.
	`A2I_ASSERT_SAME(a_ovf_sat, clk, arst_n, m_axis_tvalid && overflowed, value == SAT_POS || value == SAT_NEG, "overflowed result not saturated")

	// Without any digit the value is zero and no overflow is reported.
	`A2I_ASSERT_SAME(a_empty_zero, clk, arst_n, m_axis_tvalid && !digits_seen, value == '0 && !overflowed, "result without digits is not zero")

endmodule

bind ascii_to_integer_parser_core a2i_checker u_a2i_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/ascii_to_integer_parser_core_tb.sv -----
// ============================================================================
// ASCII to integer parser testbench
// Streams character words into the parser and checks every result word
// against a cycle-free predictor of the string conversion. Directed strings
// cover the signed range limits, base prefixes and invalid radices. Random
// strings, mostly well-formed numbers with some noise, run under random gaps
// on the input and random stalls on the output, bar a steady first phase.
// ============================================================================
`default_nettype none

module ascii_to_integer_parser_core_tb;

	import a2i_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 6;
	localparam int ITEM_COUNT    = 600;

	// Character codes that steer the parse.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_UPPER_B = 8'h42;
	localparam logic [7:0] CH_LOWER_B = 8'h62;
	localparam logic [7:0] CH_UPPER_D = 8'h44;
	localparam logic [7:0] CH_LOWER_D = 8'h64;

	typedef enum logic [2:0] {
		SCAN_SPACE,
		SCAN_SIGN,
		SCAN_ZERO,
		SCAN_PREFIX,
		SCAN_DIGITS,
		SCAN_STOPPED
	} scan_phase_t;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [IDX_W-1:0]   stop_index;
		logic               overflowed;
		logic               digits_seen;
	} parse_result_t;

	typedef logic [7:0] char_q_t[$];

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  radix_wr_en = 1'b0;
	logic [RADIX_W-1:0]    radix_wr_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [CHAR_W-1:0]     s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;

	// Predictor state, one string in flight.
	logic [RADIX_W-1:0]    cfg_radix = RADIX_RESET;
	scan_phase_t           pr_phase = SCAN_SPACE;
	logic [VALUE_W-1:0]    pr_mag = '0;
	logic [RADIX_W-1:0]    pr_base = '0;
	logic                  pr_neg = 1'b0;
	logic [IDX_W-1:0]      pr_idx = '0;
	logic [IDX_W-1:0]      pr_stop = '0;
	logic                  pr_ovf = 1'b0;

	parse_result_t         expected_results[$];
	int unsigned           fail_count = 0;
	int unsigned           cycle_count = 0;
	int unsigned           chars_sent = 0;
	logic                  steady = 1'b0;

	ascii_to_integer_parser_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.radix_wr_en   (radix_wr_en),
		.radix_wr_data (radix_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [4:0] digit_value(input logic [7:0] c);
		logic [7:0] u;
		u = c;
		if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66) u = c - 8'h20;
		if (u >= 8'h41 && u <= 8'h46) return 5'(u - 8'h37);
		return NOT_DIGIT;
	endfunction

	function automatic logic is_white(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] idx);
		return (idx >= IDX_W'(MAX_LEN)) ? IDX_W'(MAX_LEN) : idx + 1'b1;
	endfunction

	// One digit in the active base, or the end of conversion.
	task automatic accumulate(input logic [7:0] c, input logic [IDX_W-1:0] at);
		logic [4:0]         d;
		logic [VALUE_W-1:0] lim;
		logic [VALUE_W-1:0] b;
		d = digit_value(c);
		if (d >= pr_base || pr_base < 5'd2) begin
			pr_phase = SCAN_STOPPED;
			return;
		end
		b = VALUE_W'(pr_base);
		lim = pr_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		if (pr_mag > (lim - VALUE_W'(d)) / b) begin
			pr_ovf = 1'b1;
			pr_mag = lim;
		end else begin
			pr_mag = pr_mag * b + VALUE_W'(d);
		end
		pr_stop = bump(at);
		pr_phase = SCAN_DIGITS;
	endtask

	// First character after white space and sign fixes the base.
	task automatic begin_number(input logic [7:0] c, input logic [IDX_W-1:0] at);
		if (cfg_radix == '0) begin
			pr_base = 5'd10;
			if (c == CH_ZERO) begin
				pr_mag = '0;
				pr_stop = bump(at);
				pr_phase = SCAN_ZERO;
				return;
			end
		end else begin
			pr_base = (cfg_radix >= 5'd2 && cfg_radix <= 5'd16) ? cfg_radix : 5'd0;
		end
		accumulate(c, at);
	endtask

	task automatic predict_char(input logic [7:0] c, input logic last);
		logic [IDX_W-1:0] at;
		logic [4:0]       d;
		parse_result_t    r;
		at = pr_idx;
		case (pr_phase)
			SCAN_SPACE: begin
				if (c == CH_MINUS) begin
					pr_neg = 1'b1;
					pr_phase = SCAN_SIGN;
				end else if (!is_white(c)) begin
					begin_number(c, at);
				end
			end
			SCAN_SIGN: begin
				begin_number(c, at);
			end
			SCAN_ZERO: begin
				if (c == CH_LOWER_X || c == CH_UPPER_X) begin
					pr_base = 5'd16;
					pr_phase = SCAN_PREFIX;
				end else if (c == CH_LOWER_B || c == CH_UPPER_B) begin
					pr_base = 5'd2;
					pr_phase = SCAN_PREFIX;
				end else if (c == CH_LOWER_D || c == CH_UPPER_D) begin
					pr_base = 5'd10;
					pr_phase = SCAN_PREFIX;
				end else begin
					d = digit_value(c);
					if (d < 5'd10) begin
						pr_base = (d < 5'd8) ? 5'd8 : 5'd10;
						accumulate(c, at);
					end else begin
						pr_phase = SCAN_STOPPED;
					end
				end
			end
			SCAN_PREFIX, SCAN_DIGITS: begin
				accumulate(c, at);
			end
			default: begin
			end
		endcase
		pr_idx = bump(at);

		// The final character closes the string and yields one result word.
		if (last) begin
			r.value = pr_neg ? (~pr_mag + 64'd1) : pr_mag;
			r.stop_index = pr_stop;
			r.overflowed = pr_ovf;
			r.digits_seen = (pr_stop != '0);
			expected_results.push_back(r);
			pr_phase = SCAN_SPACE;
			pr_mag = '0;
			pr_base = '0;
			pr_neg = 1'b0;
			pr_idx = '0;
			pr_stop = '0;
			pr_ovf = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Output stalls fall at random except during steady stretches.
	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 22);
	end

	always @(posedge clk) begin
		parse_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("result word 0x%0h arrived with no string pending", m_axis_tdata);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("value", want.value, m_axis_tdata[VALUE_W-1:0]);
				check_field("stop_index", 64'(want.stop_index),
					64'(m_axis_tdata[OUT_STOP_LSB +: IDX_W]));
				check_field("overflowed", 64'(want.overflowed),
					64'(m_axis_tdata[OUT_OVF_BIT]));
				check_field("digits_seen", 64'(want.digits_seen),
					64'(m_axis_tdata[OUT_SEEN_BIT]));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ascii_to_integer_parser_core verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Sends one character word, with random gaps ahead of it.
	task automatic send_char(input logic [7:0] c, input logic last);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		predict_char(c, last);
		chars_sent++;
	endtask

	task automatic send_chars(input char_q_t q);
		foreach (q[i]) send_char(q[i], i == q.size() - 1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
	endtask

	// Lets every pending result drain and the pipeline go quiet.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_radix(input logic [RADIX_W-1:0] r);
		settle();
		radix_wr_en <= 1'b1;
		radix_wr_data <= r;
		cfg_radix = r;
		@(negedge clk);
		radix_wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] white_char();
		int unsigned k;
		k = $urandom_range(8, 13);
		return (k == 8) ? CH_SPACE : 8'(k);
	endfunction

	function automatic logic [7:0] digit_char(input int unsigned d);
		if (d < 10) return 8'(8'h30 + d);
		return $urandom_range(0, 1) ? 8'(8'h41 + d - 10) : 8'(8'h61 + d - 10);
	endfunction

	// A plausible number string for the given radix setting.
	function automatic char_q_t well_formed(input logic [RADIX_W-1:0] r);
		char_q_t     q;
		int unsigned base;
		int unsigned n;
		q = {};
		repeat ($urandom_range(0, 2)) q.push_back(white_char());
		if ($urandom_range(0, 9) < 3) q.push_back(CH_MINUS);
		base = (r >= 2 && r <= 16) ? int'(r) : 10;
		if (r == '0) begin
			case ($urandom_range(0, 7))
				0: begin
					q.push_back(CH_ZERO);
					q.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
					base = 16;
				end
				1: begin
					q.push_back(CH_ZERO);
					q.push_back($urandom_range(0, 1) ? CH_LOWER_B : CH_UPPER_B);
					base = 2;
				end
				2: begin
					q.push_back(CH_ZERO);
					q.push_back($urandom_range(0, 1) ? CH_LOWER_D : CH_UPPER_D);
				end
				3: begin
					q.push_back(CH_ZERO);
					base = 8;
				end
				default: begin
				end
			endcase
		end
		// Now and then a run of digits long enough that it may overflow.
		if ($urandom_range(0, 6) == 0)
			n = (base == 2) ? $urandom_range(60, 68) : $urandom_range(14, 22);
		else
			n = $urandom_range(1, 6);
		repeat (n) q.push_back(digit_char($urandom_range(0, base - 1)));
		if ($urandom_range(0, 2) == 0) q.push_back(8'($urandom_range(0, 255)));
		return q;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Signed range limits, sign handling and strings with no conversion.
	task automatic test_limits();
		char_q_t q;
		set_radix(5'd10);
		send_text("9223372036854775807");
		send_text("-9223372036854775808");
		send_text("9223372036854775808");
		send_text("-9223372036854775809");
		send_text("--5");
		send_text("+7");
		send_text("abc");
		send_text("-");
		q = {CH_SPACE, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, CH_MINUS, 8'h34, 8'h32, 8'hFF};
		send_chars(q);
		set_radix(5'd16);
		send_text("fFaA09");
		send_text("7FFFFFFFFFFFFFFFF");
	endtask

	// Prefix detection with radix 0, including lone prefixes.
	task automatic test_prefixes();
		set_radix(5'd0);
		send_text("0x1F");
		send_text("0XfF");
		send_text("0b101");
		send_text("0B2");
		send_text("0d99");
		send_text("0D");
		send_text("017");
		send_text("09");
		send_text("0");
		send_text("0x");
		send_text("0z");
		send_text("-0x8000000000000000");
		send_text("12");
	endtask

	// Every radix register value, valid and invalid.
	task automatic test_radix_sweep();
		for (int r = 0; r < 32; r++) begin
			set_radix(5'(r));
			send_text("-1aF9g");
			send_text(" 0x7b");
		end
	endtask

	// Random strings in phases of random radix settings, up to the word budget.
	task automatic test_random();
		char_q_t     q;
		int unsigned phase;
		int unsigned pos;
		logic [RADIX_W-1:0] r;
		phase = 0;
		do begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: r = 5'd0;
				4: r = 5'd10;
				5: r = 5'd16;
				6: r = 5'd2;
				7: r = 5'd8;
				8: r = 5'($urandom_range(2, 16));
				default: r = 5'($urandom_range(0, 31));
			endcase
			set_radix(r);
			// The first phase runs with no gaps and no stalls at all.
			steady = (phase == 0);
			repeat (12) begin
				case ($urandom_range(0, 9))
					0: begin
						q = {};
						repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
					end
					1: begin
						q = well_formed(r);
						pos = $urandom_range(0, q.size() - 1);
						q[pos] = 8'($urandom_range(0, 255));
					end
					default: q = well_formed(r);
				endcase
				send_chars(q);
			end
			steady = 1'b0;
			phase++;
		end while (chars_sent < ITEM_COUNT);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		test_limits();
		test_prefixes();
		test_radix_sweep();
		test_random();
		settle();
		if (fail_count == 0)
			$display("ascii_to_integer_parser_core verification clean");
		else
			$display("ascii_to_integer_parser_core verification failed");
		$finish;
	end

endmodule

`default_nettype wire
